@@ sv/pqm_pkg.sv @@
// ----------------------------------------------------------------------------
// pqm_pkg
// Types, codes and defaults used by the process queue manager.
// ----------------------------------------------------------------------------
package pqm_pkg;

    localparam int DEF_SLOTS      = 32;
    localparam int DEF_NAME_BYTES = 8;
    localparam int NUM_QUEUES     = 4;

    localparam logic [3:0] MAX_PRIO = 4'd9;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_FIND   = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD       = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    localparam logic [1:0] Q_READY = 2'd0;
    localparam logic [1:0] Q_LAST  = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  handle;
        logic [63:0] name_key;
        logic [3:0]  priority_req;
        logic        blocked;
        logic        suspended;
    } t_in;

    typedef struct packed {
        logic [1:0] status;
        logic [4:0] found_handle;
        logic [1:0] found_queue;
    } t_out;

endpackage

@@ sv/pqm_ram.sv @@
// ----------------------------------------------------------------------------
// pqm_ram
// Simple dual port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pqm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ sv/process_queue_manager.sv @@
// ----------------------------------------------------------------------------
// process_queue_manager
// Four doubly linked process queues kept in link and entry memories.
// ----------------------------------------------------------------------------
//  channel  dir  handshake                       payload
//  in       in   i_in_valid / o_in_stall         i_in_data  (t_in)
//  out      out  o_out_valid / i_out_stall       o_out_data (t_out)
//
//  one request at a time; a bad request goes straight to done, remove via
//  issue and rmw, tail insert via lnk1 and lnk2; ready-queue insert and find
//  walk one linked entry per cycle through the memory read port
//  reset clears queue heads, tails and queued flags at once, no clearing pass
//  a finished result waits in the output register while the next beat enters
// ----------------------------------------------------------------------------
module process_queue_manager
    import pqm_pkg::*;
#(
    parameter int SLOTS      = DEF_SLOTS,
    parameter int NAME_BYTES = DEF_NAME_BYTES
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    localparam int IW = $clog2(SLOTS);
    localparam int LW = IW + 1;
    localparam int NW = 8 * NAME_BYTES;
    localparam int EW = NW + 4 + 2;
    localparam logic [LW-1:0] NIL = {1'b1, {IW{1'b0}}};

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ISSUE = 3'd1;
    localparam logic [2:0] S_WALK  = 3'd2;
    localparam logic [2:0] S_LNK1  = 3'd3;
    localparam logic [2:0] S_LNK2  = 3'd4;
    localparam logic [2:0] S_RMW   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]       r_state;
    t_in              r_req;
    logic [LW-1:0]    r_cur, r_a, r_b, r_c, r_d;
    logic [1:0]       r_qi;
    logic [1:0]       r_status;
    logic [4:0]       r_fh;
    logic [1:0]       r_fq;
    logic [SLOTS-1:0] r_queued;
    logic [LW-1:0]    r_head [NUM_QUEUES];
    logic [LW-1:0]    r_tail [NUM_QUEUES];

    // memory ports
    logic          nx_we, pv_we, en_we;
    logic [IW-1:0] nx_waddr, pv_waddr, raddr;
    logic [LW-1:0] nx_wdata, pv_wdata, nx_rd, pv_rd;
    logic [EW-1:0] en_rd;

    logic          accept, in_hok, in_queued;
    logic [IW-1:0] in_hidx, hidx;
    logic [LW-1:0] hlink;
    logic [1:0]    in_q, req_q, en_q;
    logic [3:0]    en_prio;
    logic [NW-1:0] en_name;

    assign accept    = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign in_hok    = (32'(i_in_data.handle) < SLOTS);
    assign in_hidx   = IW'(i_in_data.handle);
    assign in_queued = r_queued[in_hidx];
    assign in_q      = {i_in_data.suspended, i_in_data.blocked};
    assign hidx      = IW'(r_req.handle);
    assign hlink     = {1'b0, hidx};
    assign req_q     = {r_req.suspended, r_req.blocked};
    assign {en_name, en_prio, en_q} = en_rd;

    // walk follows the next link straight out of the read data
    assign raddr = (r_state == S_WALK) ? nx_rd[IW-1:0] : r_cur[IW-1:0];

    always_comb begin
        nx_we = 1'b0; nx_waddr = hidx; nx_wdata = r_a;
        pv_we = 1'b0; pv_waddr = hidx; pv_wdata = r_b;
        en_we = 1'b0;
        case (r_state)
            S_LNK1: begin
                nx_we = 1'b1;
                pv_we = 1'b1;
                en_we = 1'b1;
            end
            S_LNK2: begin
                nx_we = !r_c[IW]; nx_waddr = r_c[IW-1:0]; nx_wdata = hlink;
                pv_we = !r_d[IW]; pv_waddr = r_d[IW-1:0]; pv_wdata = hlink;
            end
            S_RMW: begin
                nx_we = !pv_rd[IW]; nx_waddr = pv_rd[IW-1:0]; nx_wdata = nx_rd;
                pv_we = !nx_rd[IW]; pv_waddr = nx_rd[IW-1:0]; pv_wdata = pv_rd;
            end
            default: ;
        endcase
    end

    pqm_ram #(.WIDTH(LW), .DEPTH(SLOTS)) u_next (
        .i_clk(i_clk), .i_we(nx_we), .i_waddr(nx_waddr), .i_wdata(nx_wdata),
        .i_raddr(raddr), .o_rdata(nx_rd)
    );

    pqm_ram #(.WIDTH(LW), .DEPTH(SLOTS)) u_prev (
        .i_clk(i_clk), .i_we(pv_we), .i_waddr(pv_waddr), .i_wdata(pv_wdata),
        .i_raddr(raddr), .o_rdata(pv_rd)
    );

    pqm_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_entry (
        .i_clk(i_clk), .i_we(en_we), .i_waddr(hidx),
        .i_wdata({r_req.name_key[NW-1:0], r_req.priority_req, req_q}),
        .i_raddr(raddr), .o_rdata(en_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_queued    <= '0;
            o_out_valid <= 1'b0;
            for (int i = 0; i < NUM_QUEUES; i++) begin
                r_head[i] <= NIL;
                r_tail[i] <= NIL;
            end
        end else begin
            if (o_out_valid && !i_out_stall && r_state != S_DONE) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_req    <= i_in_data;
                        r_fh     <= '0;
                        r_fq     <= '0;
                        r_status <= ST_BAD;
                        r_qi     <= Q_READY;
                        r_state  <= S_DONE;
                        case (i_in_data.kind)
                            KIND_INSERT: begin
                                if (in_hok && !in_queued
                                        && i_in_data.priority_req <= MAX_PRIO) begin
                                    if (in_q != Q_READY || r_head[Q_READY][IW]) begin
                                        r_a     <= NIL;
                                        r_b     <= r_tail[in_q];
                                        r_c     <= r_tail[in_q];
                                        r_d     <= NIL;
                                        r_state <= S_LNK1;
                                    end else begin
                                        r_cur   <= r_head[Q_READY];
                                        r_state <= S_ISSUE;
                                    end
                                end
                            end
                            KIND_REMOVE: begin
                                if (in_hok && in_queued) begin
                                    r_cur   <= {1'b0, in_hidx};
                                    r_state <= S_ISSUE;
                                end
                            end
                            KIND_FIND: begin
                                r_cur   <= r_head[Q_READY];
                                r_state <= S_ISSUE;
                            end
                            default: ;
                        endcase
                    end
                end
                S_ISSUE: begin
                    if (r_req.kind == KIND_REMOVE) begin
                        r_state <= S_RMW;
                    end else if (!r_cur[IW]) begin
                        r_state <= S_WALK;
                    end else if (r_qi == Q_LAST) begin
                        r_status <= ST_NOT_FOUND;
                        r_state  <= S_DONE;
                    end else begin
                        r_qi  <= r_qi + 2'd1;
                        r_cur <= r_head[r_qi + 2'd1];
                    end
                end
                S_WALK: begin
                    if (r_req.kind == KIND_INSERT) begin
                        if (en_prio <= r_req.priority_req) begin
                            if (nx_rd[IW]) begin
                                r_a     <= NIL;
                                r_b     <= r_tail[Q_READY];
                                r_c     <= r_tail[Q_READY];
                                r_d     <= NIL;
                                r_state <= S_LNK1;
                            end else begin
                                r_cur <= nx_rd;
                            end
                        end else begin
                            // link in ahead of the current entry
                            r_a     <= r_cur;
                            r_b     <= pv_rd;
                            r_c     <= pv_rd;
                            r_d     <= r_cur;
                            r_state <= S_LNK1;
                        end
                    end else if (en_name == r_req.name_key[NW-1:0]) begin
                        r_status <= ST_OK;
                        r_fh     <= 5'(r_cur[IW-1:0]);
                        r_fq     <= r_qi;
                        r_state  <= S_DONE;
                    end else if (!nx_rd[IW]) begin
                        r_cur <= nx_rd;
                    end else if (r_qi == Q_LAST) begin
                        r_status <= ST_NOT_FOUND;
                        r_state  <= S_DONE;
                    end else begin
                        r_qi    <= r_qi + 2'd1;
                        r_cur   <= r_head[r_qi + 2'd1];
                        r_state <= S_ISSUE;
                    end
                end
                S_LNK1: begin
                    r_queued[hidx] <= 1'b1;
                    if (r_c[IW]) begin
                        r_head[req_q] <= hlink;
                    end
                    if (r_d[IW]) begin
                        r_tail[req_q] <= hlink;
                    end
                    r_state <= S_LNK2;
                end
                S_LNK2: begin
                    r_status <= ST_OK;
                    r_state  <= S_DONE;
                end
                S_RMW: begin
                    r_queued[hidx] <= 1'b0;
                    if (pv_rd[IW]) begin
                        r_head[en_q] <= nx_rd;
                    end
                    if (nx_rd[IW]) begin
                        r_tail[en_q] <= pv_rd;
                    end
                    r_status <= ST_OK;
                    r_state  <= S_DONE;
                end
                S_DONE: begin
                    if (!o_out_valid || !i_out_stall) begin
                        o_out_valid             <= 1'b1;
                        o_out_data.status       <= r_status;
                        o_out_data.found_handle <= r_fh;
                        o_out_data.found_queue  <= r_fq;
                        r_state                 <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
